// ===== rtl/gtg_pkg.sv =====
// ---------------------------------------------------------------------------
// Go-to-goal controller package
// Shared types, constants and the CORDIC arctangent table.
// ---------------------------------------------------------------------------
package gtg_pkg;

    // operation codes
    typedef enum logic [1:0] {
        OP_ODOM   = 2'd0,
        OP_TARGET = 2'd1,
        OP_TICK   = 2'd2,
        OP_NONE   = 2'd3
    } t_op;

    // configuration register indexes
    localparam logic [2:0] CFG_LIN_GAIN  = 3'd0;
    localparam logic [2:0] CFG_ANG_GAIN  = 3'd1;
    localparam logic [2:0] CFG_STOP_DIST = 3'd2;
    localparam logic [2:0] CFG_MAX_LIN   = 3'd3;
    localparam logic [2:0] CFG_MAX_TURN  = 3'd4;

    localparam int CORDIC_STEPS = 16;
    localparam int ATAN_ENTRIES = 24;
    localparam int IDX_W        = $clog2(ATAN_ENTRIES);

    localparam int XY_W  = 44;   // CORDIC x/y width
    localparam int Z_W   = 35;   // angle width, 2^-30 rad units
    localparam int MAG_W = 35;   // Q16.16 magnitude

    localparam logic signed [Z_W-1:0] PI_Z      = 35'sd3373259426;
    localparam logic [21:0]           INV_GAIN  = 22'd2547003;
    localparam logic signed [17:0]    PI_Q12    = 18'sd12868;
    localparam logic signed [17:0]    TWO_PI_Q12 = 18'sd25736;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_INIT,
        S_ITER,
        S_MAG,
        S_ERR,
        S_MUL,
        S_OUT
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic             capture;
        logic             goal_wr;
        logic             init;
        logic             step;
        logic             mag;
        logic             pose_wr;
        logic             err;
        logic             mul;
        logic             emit;
        logic [IDX_W-1:0] idx;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        t_op  op;
        logic latch;
        logic out_free;
    } t_status;

    function automatic logic signed [Z_W-1:0] atan_lut(input logic [IDX_W-1:0] i);
        logic signed [Z_W-1:0] v;
        case (i)
            5'd0:  v = 35'sh3243F6A8;
            5'd1:  v = 35'sh1DAC6705;
            5'd2:  v = 35'sh0FADBAFC;
            5'd3:  v = 35'sh07F56EA6;
            5'd4:  v = 35'sh03FEAB76;
            5'd5:  v = 35'sh01FFD55B;
            5'd6:  v = 35'sh00FFFAAA;
            5'd7:  v = 35'sh007FFF55;
            5'd8:  v = 35'sh003FFFEA;
            5'd9:  v = 35'sh001FFFFD;
            5'd10: v = 35'sh000FFFFF;
            5'd11: v = 35'sh0007FFFF;
            5'd12: v = 35'sh0003FFFF;
            5'd13: v = 35'sh0001FFFF;
            5'd14: v = 35'sh0000FFFF;
            5'd15: v = 35'sh00007FFF;
            5'd16: v = 35'sh00003FFF;
            5'd17: v = 35'sh00001FFF;
            5'd18: v = 35'sh00000FFF;
            5'd19: v = 35'sh000007FF;
            5'd20: v = 35'sh000003FF;
            5'd21: v = 35'sh000001FF;
            5'd22: v = 35'sh000000FF;
            5'd23: v = 35'sh0000007F;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

// ===== rtl/gtg_ctrl.sv =====
// ---------------------------------------------------------------------------
// Go-to-goal controller sequencer
// Walks one item through decode and, as its operation needs, CORDIC iterations, scaling and output.
// ---------------------------------------------------------------------------
module gtg_ctrl
    import gtg_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  t_status i_status,
    output logic    o_in_ready,
    output t_cmd    o_cmd
);

    t_state           r_state, n_state;
    logic [IDX_W-1:0] r_idx, n_idx;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CORDIC_STEPS - 1);

    // state and step counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) n_state = S_DECODE;
            end
            S_DECODE: begin
                if (i_status.op == OP_ODOM ||
                    (i_status.op == OP_TICK && !i_status.latch)) begin
                    n_state = S_INIT;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_INIT: begin
                n_state = S_ITER;
                n_idx   = '0;
            end
            S_ITER: begin
                n_idx = r_idx + 1'b1;
                if (r_idx == LAST_IDX) n_state = S_MAG;
            end
            S_MAG: begin
                n_state = (i_status.op == OP_ODOM) ? S_IDLE : S_ERR;
            end
            S_ERR:   n_state = S_MUL;
            S_MUL:   n_state = S_OUT;
            S_OUT: begin
                if (i_status.out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // commands
    always_comb begin
        o_cmd      = '0;
        o_cmd.idx  = r_idx;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready    = 1'b1;
                o_cmd.capture = i_in_valid;
            end
            S_DECODE: o_cmd.goal_wr = (i_status.op == OP_TARGET);
            S_INIT:   o_cmd.init    = 1'b1;
            S_ITER:   o_cmd.step    = 1'b1;
            S_MAG: begin
                o_cmd.mag     = 1'b1;
                o_cmd.pose_wr = (i_status.op == OP_ODOM);
            end
            S_ERR:    o_cmd.err     = 1'b1;
            S_MUL:    o_cmd.mul     = 1'b1;
            S_OUT:    o_cmd.emit    = i_status.out_free;
            default: ;
        endcase
    end

endmodule

// ===== rtl/gtg_dp.sv =====
// ---------------------------------------------------------------------------
// Go-to-goal controller datapath
// Pose, goal and config registers, shared CORDIC unit, multipliers, output.
// ---------------------------------------------------------------------------
module gtg_dp
    import gtg_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cmd               i_cmd,
    output t_status            o_status,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_index,
    input  logic [30:0]        i_cfg_data,
    input  logic [1:0]         i_operation,
    input  logic signed [31:0] i_coord_x,
    input  logic signed [31:0] i_coord_y,
    input  logic signed [15:0] i_quat_z,
    input  logic signed [15:0] i_quat_w,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [14:0]        o_linear_speed,
    output logic signed [15:0] o_turn_rate,
    output logic               o_goal_reached
);

    // configuration
    logic [15:0] r_lin_gain, r_ang_gain;
    logic [30:0] r_stop_dist;
    logic [14:0] r_max_lin, r_max_turn;

    // state
    logic signed [31:0] r_pose_x, r_pose_y, r_goal_x, r_goal_y;
    logic signed [15:0] r_heading;
    logic               r_latch;

    // captured item
    t_op                r_op;
    logic signed [31:0] r_cx, r_cy;
    logic signed [15:0] r_qz, r_qw;

    // working registers
    logic signed [XY_W-1:0]  r_x, r_y;
    logic signed [Z_W-1:0]   r_z;
    logic [64:0]             r_prod;
    logic [MAG_W-1:0]        r_mag;
    logic signed [17:0]      r_err;
    logic [50:0]             r_lin_p;
    logic signed [34:0]      r_turn_p;
    logic                    r_out_valid;

    // goal within stop distance
    logic                    reached;

    // config writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lin_gain  <= 16'd1229;
            r_ang_gain  <= 16'd3277;
            r_stop_dist <= 31'd6554;
            r_max_lin   <= 15'd8192;
            r_max_turn  <= 15'd16384;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_LIN_GAIN:  r_lin_gain  <= i_cfg_data[15:0];
                CFG_ANG_GAIN:  r_ang_gain  <= i_cfg_data[15:0];
                CFG_STOP_DIST: r_stop_dist <= i_cfg_data;
                CFG_MAX_LIN:   r_max_lin   <= i_cfg_data[14:0];
                CFG_MAX_TURN:  r_max_turn  <= i_cfg_data[14:0];
                default: ;
            endcase
        end
    end

    // CORDIC start vector
    logic signed [32:0]     dx, dy;
    logic signed [XY_W-1:0] ix, iy;
    always_comb begin
        dx = {r_goal_x[31], r_goal_x} - {r_pose_x[31], r_pose_x};
        dy = {r_goal_y[31], r_goal_y} - {r_pose_y[31], r_pose_y};
        if (r_op == OP_ODOM) begin
            ix = {{20{r_qw[15]}}, r_qw, 8'b0};
            iy = {{20{r_qz[15]}}, r_qz, 8'b0};
        end else begin
            ix = {{3{dx[32]}}, dx, 8'b0};
            iy = {{3{dy[32]}}, dy, 8'b0};
        end
    end

    // one rotation step
    logic signed [XY_W-1:0] xs, ys;
    logic signed [Z_W-1:0]  at;
    assign xs = r_x >>> i_cmd.idx;
    assign ys = r_y >>> i_cmd.idx;
    assign at = atan_lut(i_cmd.idx);

    // angle rounding, heading error and wrap
    logic signed [35:0] hd_sum;
    logic signed [Z_W-1:0] ang_sum;
    logic signed [16:0] ang_q;
    logic signed [17:0] err_raw, err_w;
    always_comb begin
        hd_sum  = {r_z, 1'b0} + 36'sd131072;
        ang_sum = r_z + 35'sd131072;
        ang_q   = ang_sum[34:18];
        err_raw = {ang_q[16], ang_q} - {{2{r_heading[15]}}, r_heading};
        if (err_raw > PI_Q12)       err_w = err_raw - TWO_PI_Q12;
        else if (err_raw < -PI_Q12) err_w = err_raw + TWO_PI_Q12;
        else                        err_w = err_raw;
    end

    logic [64:0] mag_sum;
    assign mag_sum = r_prod + 65'd536870912;

    // CORDIC and scaling pipeline
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op <= t_op'(i_operation);
            r_cx <= i_coord_x;
            r_cy <= i_coord_y;
            r_qz <= i_quat_z;
            r_qw <= i_quat_w;
        end
        if (i_cmd.init) begin
            if (ix < 0) begin
                r_x <= -ix;
                r_y <= -iy;
                r_z <= (iy >= 0) ? PI_Z : -PI_Z;
            end else begin
                r_x <= ix;
                r_y <= iy;
                r_z <= '0;
            end
        end else if (i_cmd.step) begin
            if (r_y > 0) begin
                r_x <= r_x + ys;
                r_y <= r_y - xs;
                r_z <= r_z + at;
            end else if (r_y < 0) begin
                r_x <= r_x - ys;
                r_y <= r_y + xs;
                r_z <= r_z - at;
            end
        end
        if (i_cmd.mag) begin
            r_prod <= 65'(r_x[42:0]) * 65'(INV_GAIN);
        end
        if (i_cmd.err) begin
            r_mag <= mag_sum[64:30];
            r_err <= err_w;
        end
        if (i_cmd.mul) begin
            r_lin_p  <= 51'(r_mag) * 51'(r_lin_gain);
            r_turn_p <= 35'(r_err) * 35'($signed({1'b0, r_ang_gain}));
        end
    end

    // pose, goal and latch
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pose_x  <= '0;
            r_pose_y  <= '0;
            r_heading <= '0;
            r_goal_x  <= '0;
            r_goal_y  <= '0;
            r_latch   <= 1'b0;
        end else begin
            if (i_cmd.pose_wr) begin
                r_pose_x  <= r_cx;
                r_pose_y  <= r_cy;
                r_heading <= hd_sum[33:18];
            end
            if (i_cmd.goal_wr) begin
                r_goal_x <= r_cx;
                r_goal_y <= r_cy;
                r_latch  <= 1'b0;
            end else if (i_cmd.emit && reached) begin
                r_latch <= 1'b1;
            end
        end
    end

    // speed commands with caps
    logic [50:0]        lin_sum;
    logic [36:0]        lin_r;
    logic [14:0]        lin_c;
    logic signed [34:0] turn_sum;
    logic signed [24:0] turn_r, lim;
    logic signed [15:0] turn_c;
    always_comb begin
        reached  = r_mag <= {4'b0, r_stop_dist};
        lin_sum  = r_lin_p + 51'd8192;
        lin_r    = lin_sum[50:14];
        lin_c    = (lin_r > 37'(r_max_lin)) ? r_max_lin : lin_r[14:0];
        turn_sum = r_turn_p + 35'sd512;
        turn_r   = turn_sum[34:10];
        lim      = $signed({10'b0, r_max_turn});
        if (turn_r > lim)       turn_c = lim[15:0];
        else if (turn_r < -lim) turn_c = 16'(-lim);
        else                    turn_c = turn_r[15:0];
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            o_linear_speed <= reached ? 15'd0 : lin_c;
            o_turn_rate    <= reached ? 16'sd0 : turn_c;
            o_goal_reached <= reached;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_status.op       = r_op;
    assign o_status.latch    = r_latch;
    assign o_status.out_free = !r_out_valid || i_out_ready;

endmodule

// ===== rtl/go_to_goal_p_controller.sv =====
// ---------------------------------------------------------------------------
// Go-to-goal proportional controller
// Odometry, target and tick items; ticks give linear and turn speed commands.
//
//   channel   direction  handshake                   payload
//   in        input      i_in_valid / o_in_ready     operation, coord, quat
//   out       output     o_out_valid / i_out_ready   speeds, goal_reached
//   cfg       input      i_cfg_we                    index, data
//
// One item at a time. A target item or ignored tick only passes decode;
// an odometry item also runs the 16 CORDIC iterations of the shared
// vectoring unit, and a control tick the scaling multiplies as well.
// Synchronous active-low reset; no clearing pass.
// A waiting result does not block the input; a tick waits only at its
// final step until the output register is free.
// ---------------------------------------------------------------------------
module go_to_goal_p_controller
    import gtg_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_index,
    input  logic [30:0]        i_cfg_data,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [1:0]         i_operation,
    input  logic signed [31:0] i_coord_x,
    input  logic signed [31:0] i_coord_y,
    input  logic signed [15:0] i_quat_z,
    input  logic signed [15:0] i_quat_w,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [14:0]        o_linear_speed,
    output logic signed [15:0] o_turn_rate,
    output logic               o_goal_reached
);

    t_cmd    cmd;
    t_status status;

    gtg_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_status   (status),
        .o_in_ready (o_in_ready),
        .o_cmd      (cmd)
    );

    gtg_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_status       (status),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_operation    (i_operation),
        .i_coord_x      (i_coord_x),
        .i_coord_y      (i_coord_y),
        .i_quat_z       (i_quat_z),
        .i_quat_w       (i_quat_w),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_linear_speed (o_linear_speed),
        .o_turn_rate    (o_turn_rate),
        .o_goal_reached (o_goal_reached)
    );

    // reached result carries zero speeds
    a_reached_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_goal_reached |-> o_linear_speed == 15'd0 && o_turn_rate == 16'sd0)
        else $error("reached result with non-zero speed");

    // turn clamp is symmetric, never the most negative code
    a_turn_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_turn_rate != -16'sd32768)
        else $error("turn rate out of range");

    // an accepted item holds the input closed in the next cycle
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("input ready right after accept");

endmodule

// ===== dv/go_to_goal_p_controller_tb.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Go-to-goal controller testbench
// Drives odometry, target, tick and unused-code items with random idling on both channels,
// predicts speed commands with a behavioural CORDIC model and checks them.
// ---------------------------------------------------------------------------

// expected speed commands, in order
class speed_scoreboard;
    logic [14:0]        q_lin[$];
    logic signed [15:0] q_turn[$];
    logic               q_reached[$];
    int                 n_bad;
    int                 n_checked;

    function void note_command(logic [14:0] lin, logic signed [15:0] turn, logic reached);
        q_lin.push_back(lin);
        q_turn.push_back(turn);
        q_reached.push_back(reached);
    endfunction

    function void check_command(logic [14:0] lin, logic signed [15:0] turn, logic reached);
        logic [14:0]        e_lin;
        logic signed [15:0] e_turn;
        logic               e_reached;
        if (q_lin.size() == 0) begin
            n_bad++;
            if (n_bad <= 10)
                $display("unexpected command lin=%0d turn=%0d reached=%0b", lin, turn, reached);
            return;
        end
        e_lin = q_lin.pop_front();
        e_turn = q_turn.pop_front();
        e_reached = q_reached.pop_front();
        n_checked++;
        if (lin !== e_lin || turn !== e_turn || reached !== e_reached) begin
            n_bad++;
            if (n_bad <= 10)
                $display("mismatch: expected lin=%0d turn=%0d reached=%0b, got %0d %0d %0b",
                         e_lin, e_turn, e_reached, lin, turn, reached);
        end
    endfunction

    function int pending();
        return q_lin.size();
    endfunction
endclass

module go_to_goal_p_controller_tb;
    import gtg_pkg::*;

    localparam int N_RANDOM  = 1030;
    localparam int MAX_CYCLE = 400000;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_cfg_we = 1'b0;
    logic [2:0]         i_cfg_index = '0;
    logic [30:0]        i_cfg_data = '0;
    logic               i_in_valid = 1'b0;
    logic               o_in_ready;
    logic [1:0]         i_operation = OP_ODOM;
    logic signed [31:0] i_coord_x = '0;
    logic signed [31:0] i_coord_y = '0;
    logic signed [15:0] i_quat_z = '0;
    logic signed [15:0] i_quat_w = '0;
    logic               o_out_valid;
    logic               i_out_ready = 1'b0;
    logic [14:0]        o_linear_speed;
    logic signed [15:0] o_turn_rate;
    logic               o_goal_reached;

    go_to_goal_p_controller uut (.*);

    always #5 i_clk = ~i_clk;

    // predictor state and register copies
    logic [15:0]        lin_gain;
    logic [15:0]        ang_gain;
    logic [30:0]        stop_dist;
    logic [14:0]        max_lin;
    logic [14:0]        max_turn;
    longint             pose_x, pose_y, pose_hdg, goal_x, goal_y;
    bit                 latched;

    speed_scoreboard    sb;
    int                 cycle;
    int                 n_items;
    int                 n_reached;
    bit                 calm;   // stretch without idling

    const longint ATAN_Q30[24] = '{
        64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76,
        64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD,
        64'h000FFFFF, 64'h0007FFFF, 64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF,
        64'h00007FFF, 64'h00003FFF, 64'h00001FFF, 64'h00000FFF, 64'h000007FF,
        64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F};

    // arithmetic shift right, floor
    function automatic longint shr_floor(longint v, int s);
        return v >>> s;
    endfunction

    // CORDIC vectoring: angle in 2^-30 rad, magnitude in input units
    task automatic vector_to(input longint vx, input longint vy,
                             output longint ang, output longint mag);
        longint x, y, z, xs, ys;
        x = vx * 256;
        y = vy * 256;
        z = 0;
        if (x < 0) begin
            z = (y >= 0) ? 64'sd3373259426 : -64'sd3373259426;
            x = -x;
            y = -y;
        end
        for (int i = 0; i < CORDIC_STEPS; i++) begin
            xs = shr_floor(x, i);
            ys = shr_floor(y, i);
            if (y > 0) begin
                x += ys; y -= xs; z += ATAN_Q30[i];
            end else if (y < 0) begin
                x -= ys; y += xs; z -= ATAN_Q30[i];
            end
        end
        ang = z;
        mag = (x * 64'sd2547003 + (64'sd1 << 29)) >>> 30;
    endtask

    // apply one accepted item to the predictor
    task automatic predict_item(input logic [1:0] op, input logic signed [31:0] cx,
                                input logic signed [31:0] cy, input logic signed [15:0] qz,
                                input logic signed [15:0] qw);
        longint ang, mag, lin, err, turn;
        case (op)
            OP_ODOM: begin
                vector_to(longint'(qw), longint'(qz), ang, mag);
                pose_x = cx;
                pose_y = cy;
                pose_hdg = (2 * ang + (64'sd1 << 17)) >>> 18;
            end
            OP_TARGET: begin
                goal_x = cx;
                goal_y = cy;
                latched = 0;
            end
            OP_TICK: begin
                if (!latched) begin
                    vector_to(goal_x - pose_x, goal_y - pose_y, ang, mag);
                    if (mag <= longint'(stop_dist)) begin
                        latched = 1;
                        n_reached++;
                        sb.note_command('0, '0, 1'b1);
                    end else begin
                        lin = (longint'(lin_gain) * mag + 8192) >>> 14;
                        if (lin > longint'(max_lin)) lin = max_lin;
                        err = ((ang + (64'sd1 << 17)) >>> 18) - pose_hdg;
                        while (err > 12868) err -= 25736;
                        while (err < -12868) err += 25736;
                        turn = (longint'(ang_gain) * err + 512) >>> 10;
                        if (turn > longint'(max_turn)) turn = max_turn;
                        if (turn < -longint'(max_turn)) turn = -longint'(max_turn);
                        sb.note_command(lin[14:0], turn[15:0], 1'b0);
                    end
                end
            end
            default: ;
        endcase
    endtask

    // register write, block idle; the caller drops the enable
    task automatic write_reg(input logic [2:0] idx, input logic [30:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        case (idx)
            CFG_LIN_GAIN:  lin_gain = val[15:0];
            CFG_ANG_GAIN:  ang_gain = val[15:0];
            CFG_STOP_DIST: stop_dist = val;
            CFG_MAX_LIN:   max_lin = val[14:0];
            CFG_MAX_TURN:  max_turn = val[14:0];
            default: ;
        endcase
    endtask

    task automatic set_all(input logic [15:0] lg, input logic [15:0] ag,
                           input logic [30:0] sd, input logic [14:0] ml,
                           input logic [14:0] mt);
        write_reg(CFG_LIN_GAIN, 31'(lg));
        write_reg(CFG_ANG_GAIN, 31'(ag));
        write_reg(CFG_STOP_DIST, sd);
        write_reg(CFG_MAX_LIN, 31'(ml));
        write_reg(CFG_MAX_TURN, 31'(mt));
        i_cfg_we <= 1'b0;
    endtask

    // close the input, wait for every result, then let the datapath settle
    task automatic drain();
        i_in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (30) @(posedge i_clk);
    endtask

    // offer one item and hold it until accepted; valid drops only while idling
    task automatic send_item(input logic [1:0] op, input logic signed [31:0] cx,
                             input logic signed [31:0] cy, input logic signed [15:0] qz,
                             input logic signed [15:0] qw);
        while (!calm && $urandom_range(99) < 10) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_operation <= op;
        i_coord_x <= cx;
        i_coord_y <= cy;
        i_quat_z <= qz;
        i_quat_w <= qw;
        do @(posedge i_clk); while (!o_in_ready);
        predict_item(op, cx, cy, qz, qw);
        n_items++;
    endtask

    function automatic logic signed [15:0] rand_quat();
        return 16'($signed($urandom_range(32768)) - 16384);
    endfunction

    // mostly small ranges so goals and stop distances interact
    function automatic logic signed [31:0] rand_coord();
        case ($urandom_range(3))
            0: return $urandom;
            1: return 32'($signed($urandom_range(2000000)) - 1000000);
            default: return 32'($signed($urandom_range(40000)) - 20000);
        endcase
    endfunction

    // output side: random stalls, checks on acceptance
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready)
                sb.check_command(o_linear_speed, o_turn_rate, o_goal_reached);
            i_out_ready <= calm || ($urandom_range(99) >= 10);
        end
    end

    // run limit
    always @(posedge i_clk) begin
        cycle <= cycle + 1;
        if (cycle > MAX_CYCLE) begin
            $display("timeout after %0d cycles", cycle);
            $display("tb: failure");
            $finish;
        end
    end

    initial begin
        logic [1:0] op;
        int         r;
        sb = new();
        cycle = 0;
        n_items = 0;
        n_reached = 0;
        calm = 0;
        lin_gain = 1229; ang_gain = 3277; stop_dist = 6554; max_lin = 8192; max_turn = 16384;
        pose_x = 0; pose_y = 0; pose_hdg = 0; goal_x = 0; goal_y = 0; latched = 0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: zero vector, extremes, all operations, latch behaviour
        send_item(OP_TICK, 0, 0, 0, 0);
        send_item(OP_TICK, 0, 0, 0, 0);
        send_item(OP_TARGET, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 0, 0);
        send_item(OP_ODOM, 32'sh80000000, 32'sh80000000, 16'sd16384, -16'sd16384);
        send_item(OP_TICK, 0, 0, 0, 0);
        send_item(OP_ODOM, 32'sh7FFFFFFF, 32'sh80000000, -16'sd16384, 16'sd0);
        send_item(OP_TICK, -1, -1, -1, -1);
        send_item(OP_ODOM, 0, 0, 16'sd0, -16'sd16384);
        send_item(OP_TARGET, -32'sd65536, 0, 0, 0);
        send_item(OP_TICK, 0, 0, 0, 0);
        send_item(OP_NONE, -1, -1, -1, -1);
        send_item(OP_TARGET, 32'sh80000000, 32'sh7FFFFFFF, 0, 0);
        send_item(OP_TICK, 0, 0, 0, 0);
        send_item(OP_TARGET, 100, -100, 0, 0);
        send_item(OP_ODOM, 0, 0, 16'sd11585, 16'sd11585);
        send_item(OP_TICK, 0, 0, 0, 0);
        send_item(OP_TICK, 0, 0, 0, 0);
        drain();

        // extremes of every register
        set_all(16'hFFFF, 16'hFFFF, 31'd0, 15'h7FFF, 15'h7FFF);
        send_item(OP_TARGET, 32'sd70000, -32'sd300000, 0, 0);
        send_item(OP_TICK, 0, 0, 0, 0);
        send_item(OP_TARGET, 0, 0, 0, 0);
        send_item(OP_ODOM, 0, 0, 16'sd16384, 16'sd0);
        send_item(OP_TICK, 0, 0, 0, 0);
        drain();
        set_all(16'd0, 16'd0, 31'h7FFFFFFF, 15'd0, 15'd0);
        send_item(OP_TICK, 0, 0, 0, 0);
        send_item(OP_TARGET, 32'sh7FFFFFFF, 0, 0, 0);
        send_item(OP_TICK, 0, 0, 0, 0);
        drain();

        // random phases, each under its own settings
        for (int ph = 0; ph < 6; ph++) begin
            if (ph == 5)
                set_all(16'd1229, 16'd3277, 31'd6554, 15'd8192, 15'd16384);
            else
                set_all(16'($urandom), 16'($urandom),
                        31'($urandom_range(1) ? $urandom_range(200000) : $urandom),
                        15'($urandom), 15'($urandom));
            calm = (ph == 2);
            for (int k = 0; k < N_RANDOM / 6; k++) begin
                r = $urandom_range(99);
                op = (r < 15) ? OP_ODOM : (r < 27) ? OP_TARGET : (r < 97) ? OP_TICK : OP_NONE;
                send_item(op, rand_coord(), rand_coord(), rand_quat(),
                          ($urandom_range(9) == 0) ? 16'($urandom) : rand_quat());
            end
            drain();
        end
        calm = 0;

        $display("covered %0d items, %0d commands checked, %0d goal-reached results",
                 n_items, sb.n_checked, n_reached);
        if (sb.n_bad == 0 && sb.pending() == 0) begin
            $display("tb: success");
        end else begin
            $display("%0d mismatches, %0d commands outstanding", sb.n_bad, sb.pending());
            $display("tb: failure");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/gtg_pkg.sv
rtl/gtg_ctrl.sv
rtl/gtg_dp.sv
rtl/go_to_goal_p_controller.sv
dv/go_to_goal_p_controller_tb.sv
